// File: design/bif_pkg.sv
// ---------------------------------------------------------------------------
// bif_pkg: shared types and constants for the bone influence table
// Field widths, register codes, chain operations and the controller states.
// ---------------------------------------------------------------------------
package bif_pkg;

  // Default table depth of the cell chain.
  localparam int unsigned BIF_MAX_INFLUENCES = 16;

  // Field widths.
  localparam int unsigned BONE_W   = 10;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned KEPT_W   = 5;
  localparam int unsigned MBC_W    = 5;
  localparam int unsigned Q_W      = 16;

  // At most this many influences leave one finalize.
  localparam int unsigned KEEP_LIMIT = 16;

  // Register reset values.
  localparam logic [MBC_W-1:0]    MAX_BONE_RESET  = 5'd4;
  localparam logic [WEIGHT_W-1:0] THRESHOLD_RESET = 16'd0;

  // One in unsigned Q1.15.
  localparam logic [Q_W-1:0] ONE_Q15 = 16'h8000;

  // Item action codes.
  typedef enum logic {
    ACT_ADD,
    ACT_FINALIZE
  } bif_action_e;

  // Register index, taken from the word address.
  typedef enum logic {
    REG_MAX_BONE,
    REG_THRESHOLD
  } bif_reg_e;

  // Operation applied to every cell of the chain together.
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE,
    OP_SHIFT
  } bif_op_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INSERT,
    ST_SCAN,
    ST_SEEK,
    ST_DIV,
    ST_OUT,
    ST_EMPTY
  } bif_state_e;

  // Control broadcast to all cells.
  typedef struct packed {
    bif_op_e               op;
    logic [BONE_W-1:0]     match_bone;
    logic [BONE_W-1:0]     key_bone;
    logic [WEIGHT_W-1:0]   key_weight;
  } bif_chain_t;

endpackage

// File: design/bone_influence_table.sv
// ---------------------------------------------------------------------------
// bone_influence_table: per-vertex top-k bone influence selector
// Sorted chain of influence cells with pruning and Q1.15 normalization.
// ---------------------------------------------------------------------------
// Usage:
//   Input items (in_valid_i/in_ready_o) either add a bone weight to the
//   current vertex or finalize it. An add first finds a cell holding the
//   same bone, then moves the chain so the table stays sorted by descending
//   weight. An add produces no result. A finalize first rotates the chain
//   once over its filled cells to count the survivors and sum their
//   weights. It then walks the chain, shifting past entries that are not
//   kept and normalizing each emitted influence with the bit-serial divider
//   (16 steps). An empty vertex gives one result. The last result carries
//   last_o; the table and the overflow flag are then clear and the block
//   takes new items while that result still waits. Results sit in an output
//   register; when it is full and out_ready_i is low, the divider result
//   waits and the chain holds. Reset empties the table, clears the overflow
//   flag, and sets max_bone_count to 4 and weight_threshold to 0. Registers
//   are written over the APB port; the user must write them only while the
//   block is idle, which the block itself does not enforce. Word 0 is
//   max_bone_count and word 1 is weight_threshold.
// ---------------------------------------------------------------------------
module bone_influence_table #(
  parameter int unsigned MAX_INFLUENCES = bif_pkg::BIF_MAX_INFLUENCES
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Item input channel.
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          action_i,
  input  logic [bif_pkg::BONE_W-1:0]    bone_id_i,
  input  logic [bif_pkg::WEIGHT_W-1:0]  weight_i,
  // Result channel.
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [bif_pkg::BONE_W-1:0]    bone_id_res_o,
  output logic [bif_pkg::Q_W-1:0]       norm_weight_o,
  output logic                          valid_res_o,
  output logic                          last_o,
  output logic [bif_pkg::KEPT_W-1:0]    kept_count_o,
  output logic                          overflowed_o,
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import bif_pkg::*;

  localparam int unsigned N        = MAX_INFLUENCES;
  localparam int unsigned CNT_W    = $clog2(N + 1);
  localparam int unsigned IDX_W    = $clog2(N);
  localparam int unsigned KEEP_MAX = (N < KEEP_LIMIT) ? N : KEEP_LIMIT;
  localparam int unsigned TOT_W    = WEIGHT_W + $clog2(KEEP_MAX);
  localparam int unsigned NUM_W    = TOT_W + Q_W;

  // Controller and table state.
  bif_state_e          state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;
  logic                ovf_q, ovf_d;
  logic [IDX_W-1:0]    scan_q, scan_d;
  logic [KEPT_W-1:0]   kept_q, kept_d;
  logic [TOT_W-1:0]    total_q, total_d;
  logic [KEPT_W-1:0]   emit_q, emit_d;

  // Add key latched in the match cycle.
  logic [BONE_W-1:0]   key_bone_q;
  logic [WEIGHT_W-1:0] key_w_q;
  logic [IDX_W-1:0]    k_q;
  logic                grow_q;
  logic [BONE_W-1:0]   res_bone_q;

  // Configuration registers.
  logic [MBC_W-1:0]    mbc_q;
  logic [WEIGHT_W-1:0] thr_q;

  // Output register.
  logic                out_valid_q;
  logic [BONE_W-1:0]   out_bone_q;
  logic [Q_W-1:0]      out_norm_q;
  logic                out_vres_q;
  logic                out_last_q;
  logic [KEPT_W-1:0]   out_kept_q;
  logic                out_ovf_q;

  // Chain wiring.
  bif_chain_t          chain;
  bif_op_e             op;
  logic [BONE_W-1:0]   cell_bone   [N];
  logic [WEIGHT_W-1:0] cell_w      [N];
  logic                cell_lighter[N];
  logic                cell_match  [N];

  // Match results and helpers.
  logic                match_any;
  logic [WEIGHT_W-1:0] match_w;
  logic [IDX_W-1:0]    match_idx;
  logic [WEIGHT_W:0]   acc_sum;
  logic [WEIGHT_W-1:0] acc_sat;
  logic                full;
  logic                add_take;
  logic [KEPT_W-1:0]   limit;
  logic                head_pass;
  logic                slot_free;
  logic                res_last;
  logic                out_load;
  logic                out_empty;
  logic                div_start;
  logic                div_done;
  logic [NUM_W-1:0]    div_numer;
  logic [TOT_W-1:0]    div_denom;
  logic [Q_W-1:0]      div_quot;
  logic                cfg_write;

  // Configuration port.
  assign cfg_write = psel && penable && pwrite;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == REG_THRESHOLD) ? {16'b0, thr_q} : {27'b0, mbc_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mbc_q <= MAX_BONE_RESET;
      thr_q <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      if (paddr[2] == REG_MAX_BONE) begin
        mbc_q <= pwdata[MBC_W-1:0];
      end else begin
        thr_q <= pwdata[WEIGHT_W-1:0];
      end
    end
  end

  // Cell chain.
  assign chain.op         = op;
  assign chain.match_bone = bone_id_i;
  assign chain.key_bone   = key_bone_q;
  assign chain.key_weight = key_w_q;

  for (genvar j = 0; j < N; j++) begin : g_cell
    logic [BONE_W-1:0]   prev_bone;
    logic [WEIGHT_W-1:0] prev_w;
    logic                prev_lighter;
    logic [BONE_W-1:0]   next_bone;
    logic [WEIGHT_W-1:0] next_w;

    if (j == 0) begin : g_first
      assign prev_bone    = '0;
      assign prev_w       = '0;
      assign prev_lighter = 1'b0;
    end else begin : g_inner
      assign prev_bone    = cell_bone[j-1];
      assign prev_w       = cell_w[j-1];
      assign prev_lighter = cell_lighter[j-1];
    end

    if (j == N - 1) begin : g_tail
      assign next_bone = '0;
      assign next_w    = '0;
    end else begin : g_body
      assign next_bone = cell_bone[j+1];
      assign next_w    = cell_w[j+1];
    end

    bif_cell #(
      .CNT_W(CNT_W),
      .IDX_W(IDX_W),
      .IDX  (j)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (chain),
      .k_i           (k_q),
      .count_i       (count_q),
      .prev_bone_i   (prev_bone),
      .prev_weight_i (prev_w),
      .prev_lighter_i(prev_lighter),
      .next_bone_i   (next_bone),
      .next_weight_i (next_w),
      .head_bone_i   (cell_bone[0]),
      .head_weight_i (cell_w[0]),
      .bone_o        (cell_bone[j]),
      .weight_o      (cell_w[j]),
      .lighter_o     (cell_lighter[j]),
      .match_o       (cell_match[j])
    );
  end

  // Gather the matching cell, if any; bones in the table are unique.
  always_comb begin
    match_any = 1'b0;
    match_w   = '0;
    match_idx = '0;
    for (int j = 0; j < N; j++) begin
      if (cell_match[j]) begin
        match_any = 1'b1;
        match_w   = match_w | cell_w[j];
        match_idx = match_idx | IDX_W'(j);
      end
    end
  end

  // Saturating accumulation of a repeated bone.
  assign acc_sum  = {1'b0, match_w} + {1'b0, weight_i};
  assign acc_sat  = acc_sum[WEIGHT_W] ? '1 : acc_sum[WEIGHT_W-1:0];
  assign full     = count_q == CNT_W'(N);
  assign add_take = (state_q == ST_IDLE) && in_valid_i && (action_i == ACT_ADD);

  // Finalize selection helpers.
  assign limit     = (mbc_q > KEPT_W'(KEEP_MAX)) ? KEPT_W'(KEEP_MAX) : mbc_q;
  assign head_pass = cell_w[0] >= thr_q;
  assign slot_free = !out_valid_q || out_ready_i;
  assign res_last  = (emit_q + KEPT_W'(1)) == kept_q;

  // Divider operands: weight share of the total, or an even split.
  always_comb begin
    if (total_q != '0) begin
      div_numer = (NUM_W'(cell_w[0]) << 15) + NUM_W'(total_q >> 1);
      div_denom = total_q;
    end else begin
      div_numer = NUM_W'(ONE_Q15) + NUM_W'(kept_q >> 1);
      div_denom = TOT_W'(kept_q);
    end
  end

  bif_div #(
    .TOT_W(TOT_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .numer_i(div_numer),
    .denom_i(div_denom),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  // Next state, chain operation and result loading.
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    ovf_d     = ovf_q;
    scan_d    = scan_q;
    kept_d    = kept_q;
    total_d   = total_q;
    emit_d    = emit_q;
    op        = OP_HOLD;
    div_start = 1'b0;
    out_load  = 1'b0;
    out_empty = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (action_i == ACT_ADD) begin
            if (!match_any && full) begin
              ovf_d = 1'b1;
            end
            state_d = ST_INSERT;
          end else begin
            kept_d  = '0;
            total_d = '0;
            scan_d  = '0;
            emit_d  = '0;
            state_d = (count_q == '0) ? ST_EMPTY : ST_SCAN;
          end
        end
      end
      ST_INSERT: begin
        op = OP_INSERT;
        if (grow_q) begin
          count_d = count_q + CNT_W'(1);
        end
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        op = OP_ROTATE;
        if (head_pass && (kept_q < limit)) begin
          kept_d  = kept_q + KEPT_W'(1);
          total_d = total_q + TOT_W'(cell_w[0]);
        end
        scan_d = scan_q + IDX_W'(1);
        if (scan_q == IDX_W'(count_q - CNT_W'(1))) begin
          state_d = (kept_d == '0) ? ST_EMPTY : ST_SEEK;
        end
      end
      ST_SEEK: begin
        if (head_pass && (emit_q < kept_q)) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          op = OP_SHIFT;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (slot_free) begin
          out_load = 1'b1;
          op       = OP_SHIFT;
          emit_d   = emit_q + KEPT_W'(1);
          if (res_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_IDLE;
          end else begin
            state_d = ST_SEEK;
          end
        end
      end
      ST_EMPTY: begin
        if (slot_free) begin
          out_load  = 1'b1;
          out_empty = 1'b1;
          count_d   = '0;
          ovf_d     = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = state_q == ST_IDLE;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      scan_q      <= '0;
      kept_q      <= '0;
      total_q     <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      scan_q  <= scan_d;
      kept_q  <= kept_d;
      total_q <= total_d;
      emit_q  <= emit_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Add key: the weight after accumulation and the last cell that may move.
  always_ff @(posedge clk_i) begin
    if (add_take) begin
      key_bone_q <= bone_id_i;
      key_w_q    <= match_any ? acc_sat : weight_i;
      if (match_any) begin
        k_q <= match_idx;
      end else if (full) begin
        k_q <= IDX_W'(N - 1);
      end else begin
        k_q <= count_q[IDX_W-1:0];
      end
      grow_q <= !match_any && !full;
    end
    if (div_start) begin
      res_bone_q <= cell_bone[0];
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_bone_q <= out_empty ? '0 : res_bone_q;
      out_norm_q <= out_empty ? '0 : div_quot;
      out_vres_q <= !out_empty;
      out_last_q <= out_empty || res_last;
      out_kept_q <= out_empty ? '0 : kept_q;
      out_ovf_q  <= ovf_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign bone_id_res_o = out_bone_q;
  assign norm_weight_o = out_norm_q;
  assign valid_res_o   = out_vres_q;
  assign last_o        = out_last_q;
  assign kept_count_o  = out_kept_q;
  assign overflowed_o  = out_ovf_q;

  // Checks on the table and the controller.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(N))
    else $error("table fill exceeds its depth");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (out_empty || res_last)) |=> (count_q == '0 && !ovf_q && in_ready_o))
    else $error("table not cleared after the final result");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && count_q >= CNT_W'(2)) |-> (cell_w[0] >= cell_w[1]))
    else $error("chain head out of weight order");

endmodule

// File: design/bif_cell.sv
// ---------------------------------------------------------------------------
// bif_cell: one entry of the sorted influence chain
// Holds one bone and weight, compares against the broadcast key, and loads
// the key, the head or its left or right neighbor as the chain op requires.
// ---------------------------------------------------------------------------
module bif_cell #(
  parameter int unsigned CNT_W = 5,
  parameter int unsigned IDX_W = 4,
  parameter int unsigned IDX   = 0
) (
  input  logic                          clk_i,
  input  bif_pkg::bif_chain_t           ctl_i,
  input  logic [IDX_W-1:0]              k_i,
  input  logic [CNT_W-1:0]              count_i,
  input  logic [bif_pkg::BONE_W-1:0]    prev_bone_i,
  input  logic [bif_pkg::WEIGHT_W-1:0]  prev_weight_i,
  input  logic                          prev_lighter_i,
  input  logic [bif_pkg::BONE_W-1:0]    next_bone_i,
  input  logic [bif_pkg::WEIGHT_W-1:0]  next_weight_i,
  input  logic [bif_pkg::BONE_W-1:0]    head_bone_i,
  input  logic [bif_pkg::WEIGHT_W-1:0]  head_weight_i,
  output logic [bif_pkg::BONE_W-1:0]    bone_o,
  output logic [bif_pkg::WEIGHT_W-1:0]  weight_o,
  output logic                          lighter_o,
  output logic                          match_o
);
  import bif_pkg::*;

  logic [BONE_W-1:0]   bone_q, bone_d;
  logic [WEIGHT_W-1:0] weight_q, weight_d;
  logic                occupied;
  logic                in_range;
  logic                rot_wrap;
  logic                rot_inner;

  // Position of this cell relative to the fill level and the move range.
  assign occupied  = CNT_W'(IDX) < count_i;
  assign in_range  = IDX_W'(IDX) <= k_i;
  assign rot_wrap  = CNT_W'(IDX + 1) == count_i;
  assign rot_inner = CNT_W'(IDX + 1) < count_i;

  // An empty cell counts as lighter than any key, so the lighter flags form
  // a thermometer along the chain.
  assign lighter_o = !occupied || (weight_q < ctl_i.key_weight);
  assign match_o   = occupied && (bone_q == ctl_i.match_bone);

  // Next entry value for the broadcast operation.
  always_comb begin
    bone_d   = bone_q;
    weight_d = weight_q;
    unique case (ctl_i.op)
      OP_INSERT: begin
        if (in_range && prev_lighter_i) begin
          bone_d   = prev_bone_i;
          weight_d = prev_weight_i;
        end else if (in_range && lighter_o) begin
          bone_d   = ctl_i.key_bone;
          weight_d = ctl_i.key_weight;
        end
      end
      OP_ROTATE: begin
        if (rot_wrap) begin
          bone_d   = head_bone_i;
          weight_d = head_weight_i;
        end else if (rot_inner) begin
          bone_d   = next_bone_i;
          weight_d = next_weight_i;
        end
      end
      OP_SHIFT: begin
        bone_d   = next_bone_i;
        weight_d = next_weight_i;
      end
      default: begin
        bone_d   = bone_q;
        weight_d = weight_q;
      end
    endcase
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    bone_q   <= bone_d;
    weight_q <= weight_d;
  end

  assign bone_o   = bone_q;
  assign weight_o = weight_q;

endmodule

// File: design/bif_div.sv
// ---------------------------------------------------------------------------
// bif_div: restoring divider for weight normalization
// Produces a Q_W-bit quotient one bit per cycle; the numerator must be below
// the denominator times two to the Q_W.
// ---------------------------------------------------------------------------
module bif_div #(
  parameter int unsigned TOT_W = 20
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [TOT_W+bif_pkg::Q_W-1:0]     numer_i,
  input  logic [TOT_W-1:0]                  denom_i,
  output logic                              done_o,
  output logic [bif_pkg::Q_W-1:0]           quot_o
);
  import bif_pkg::*;

  localparam int unsigned STEP_W = $clog2(Q_W + 1);

  logic [TOT_W-1:0]  rem_q, rem_d;
  logic [TOT_W-1:0]  den_q, den_d;
  logic [Q_W-1:0]    quo_q, quo_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [TOT_W:0]    shifted;
  logic [TOT_W:0]    trial;

  // One trial subtraction per cycle.
  assign shifted = {rem_q, quo_q[Q_W-1]};
  assign trial   = shifted - {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (start_i) begin
      rem_d  = numer_i[TOT_W+Q_W-1:Q_W];
      quo_d  = numer_i[Q_W-1:0];
      den_d  = denom_i;
      step_d = STEP_W'(Q_W);
    end else if (step_q != '0) begin
      if (!trial[TOT_W]) begin
        rem_d = trial[TOT_W-1:0];
        quo_d = {quo_q[Q_W-2:0], 1'b1};
      end else begin
        rem_d = shifted[TOT_W-1:0];
        quo_d = {quo_q[Q_W-2:0], 1'b0};
      end
      step_d = step_q - STEP_W'(1);
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else begin
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  // The quotient is complete after the cycle in which the last step runs.
  assign done_o = step_q == STEP_W'(1);
  assign quot_o = quo_q;

endmodule

// File: sim/bone_influence_table_tb.sv
// ---------------------------------------------------------------------------
// bone_influence_table_tb: self-checking bench for the bone influence table
// Drives add and finalize items through the valid/ready input, predicts the
// sorted table, pruning and Q1.15 normalization in the bench, and checks
// every emitted influence in order. Runs directed corner cases, random
// vertices over several register settings, a long output hold-off, and a
// final stretch with no idling.
// ---------------------------------------------------------------------------
module bone_influence_table_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bif_pkg::*;

  localparam int unsigned TABLE_DEPTH    = BIF_MAX_INFLUENCES;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned HOLD_CYCLES    = 300;

  // One emitted influence as the bench expects it.
  typedef struct packed {
    logic [BONE_W-1:0] bone;
    logic [Q_W-1:0]    weight;
    logic              valid;
    logic              last;
    logic [KEPT_W-1:0] kept;
    logic              ovf;
  } influence_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_ready_o;
  logic                action_i    = 1'b0;
  logic [BONE_W-1:0]   bone_id_i   = '0;
  logic [WEIGHT_W-1:0] weight_i    = '0;
  logic                out_valid_o;
  logic                out_ready_i = 1'b0;
  logic [BONE_W-1:0]   bone_id_res_o;
  logic [Q_W-1:0]      norm_weight_o;
  logic                valid_res_o;
  logic                last_o;
  logic [KEPT_W-1:0]   kept_count_o;
  logic                overflowed_o;
  logic                psel        = 1'b0;
  logic                penable     = 1'b0;
  logic                pwrite      = 1'b0;
  logic [2:0]          paddr       = '0;
  logic [31:0]         pwdata      = '0;
  logic [31:0]         prdata;
  logic                pready;

  // Bench copy of the influence table and the registers.
  logic [BONE_W-1:0]   tbl_bone   [TABLE_DEPTH];
  logic [WEIGHT_W-1:0] tbl_weight [TABLE_DEPTH];
  int unsigned         tbl_count;
  logic                tbl_ovf;
  logic [MBC_W-1:0]    cfg_max_bones;
  logic [WEIGHT_W-1:0] cfg_threshold;

  influence_t  pending_influences[$];
  int unsigned error_count  = 0;
  int unsigned items_sent   = 0;
  int unsigned stuck_cycles = 0;
  int unsigned hold_request = 0;
  bit          no_idle      = 1'b0;

  bone_influence_table #(
    .MAX_INFLUENCES(TABLE_DEPTH)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .action_i     (action_i),
    .bone_id_i    (bone_id_i),
    .weight_i     (weight_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .bone_id_res_o(bone_id_res_o),
    .norm_weight_o(norm_weight_o),
    .valid_res_o  (valid_res_o),
    .last_o       (last_o),
    .kept_count_o (kept_count_o),
    .overflowed_o (overflowed_o),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always #10 clk_i = ~clk_i;

  // Mismatch reporting.
  task automatic report_error(string msg);
    $display("%0t ns ERROR: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      report_error($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  // Append one influence to the expected stream.
  function automatic void expect_influence(influence_t r);
    pending_influences = {pending_influences, r};
  endfunction

  // Table update for an add: accumulate into a matching bone or insert.
  function automatic void table_add(logic [BONE_W-1:0] bone, logic [WEIGHT_W-1:0] w);
    int unsigned         i;
    int unsigned         pos;
    int unsigned         sum;
    logic [BONE_W-1:0]   tb;
    logic [WEIGHT_W-1:0] tw;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_bone[i] == bone) begin
        sum = 32'(tbl_weight[i]) + 32'(w);
        if (sum > 32'hFFFF) sum = 32'hFFFF;
        tbl_weight[i] = sum[WEIGHT_W-1:0];
        // Bubble forward only past strictly lighter entries.
        while (i > 0 && tbl_weight[i-1] < tbl_weight[i]) begin
          tb = tbl_bone[i-1];
          tw = tbl_weight[i-1];
          tbl_bone[i-1]   = tbl_bone[i];
          tbl_weight[i-1] = tbl_weight[i];
          tbl_bone[i]     = tb;
          tbl_weight[i]   = tw;
          i--;
        end
        return;
      end
    end
    // A full table replaces its lightest entry only with a heavier one.
    if (tbl_count >= TABLE_DEPTH) begin
      tbl_ovf = 1'b1;
      if (w <= tbl_weight[TABLE_DEPTH-1]) return;
      tbl_count = TABLE_DEPTH - 1;
    end
    pos = tbl_count;
    while (pos > 0 && tbl_weight[pos-1] < w) begin
      tbl_bone[pos]   = tbl_bone[pos-1];
      tbl_weight[pos] = tbl_weight[pos-1];
      pos--;
    end
    tbl_bone[pos]   = bone;
    tbl_weight[pos] = w;
    tbl_count++;
  endfunction

  // Finalize: prune, normalize, queue the expected influences, clear.
  function automatic void table_finalize();
    int unsigned       limit;
    int unsigned       kept;
    int unsigned       total;
    int unsigned       sel [TABLE_DEPTH];
    int unsigned       i;
    longint unsigned   nw;
    influence_t        r;
    limit = 32'(cfg_max_bones);
    if (limit > TABLE_DEPTH) limit = TABLE_DEPTH;
    if (limit > KEEP_LIMIT) limit = KEEP_LIMIT;
    kept  = 0;
    total = 0;
    for (i = 0; i < tbl_count && kept < limit; i++) begin
      if (tbl_weight[i] >= cfg_threshold) begin
        sel[kept] = i;
        total += 32'(tbl_weight[i]);
        kept++;
      end
    end
    if (kept == 0) begin
      r = '0;
      r.last = 1'b1;
      r.ovf  = tbl_ovf;
      expect_influence(r);
    end else begin
      for (i = 0; i < kept; i++) begin
        // A zero total falls back to equal shares.
        if (total == 0) begin
          nw = (64'(ONE_Q15) + 64'(kept / 2)) / 64'(kept);
        end else begin
          nw = (64'(tbl_weight[sel[i]]) * 64'(ONE_Q15) + 64'(total / 2)) / 64'(total);
        end
        r.bone   = tbl_bone[sel[i]];
        r.weight = nw[Q_W-1:0];
        r.valid  = 1'b1;
        r.last   = (i + 1 == kept);
        r.kept   = kept[KEPT_W-1:0];
        r.ovf    = tbl_ovf;
        expect_influence(r);
      end
    end
    tbl_count = 0;
    tbl_ovf   = 1'b0;
  endfunction

  // Send one item, with an optional idle burst in front of it.
  task automatic send_item(bif_action_e act, logic [BONE_W-1:0] bone,
                           logic [WEIGHT_W-1:0] w);
    int unsigned gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    bone_id_i  <= bone;
    weight_i   <= w;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (act == ACT_ADD) table_add(bone, w);
    else table_finalize();
  endtask

  // Register write followed by a read-back of the same register.
  task automatic apb_write(bif_reg_e idx, logic [31:0] data);
    logic [31:0] mask;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_MAX_BONE) begin
      cfg_max_bones = data[MBC_W-1:0];
      mask = 32'h1F;
    end else begin
      cfg_threshold = data[WEIGHT_W-1:0];
      mask = 32'hFFFF;
    end
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    check_field($sformatf("register %0d readback", idx), prdata & mask, data & mask);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] max_bones, logic [31:0] threshold);
    apb_write(REG_MAX_BONE, max_bones);
    apb_write(REG_THRESHOLD, threshold);
  endtask

  // Lower valid and let every expected influence come out.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_influences.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Bones mostly from a small pool so repeats and a full table are common.
  function automatic logic [BONE_W-1:0] pick_bone(int unsigned span);
    if ($urandom_range(0, 3) == 0) return BONE_W'($urandom_range(0, 1023));
    return BONE_W'($urandom_range(0, span));
  endfunction

  // Weights biased toward zero, saturation and ties.
  function automatic logic [WEIGHT_W-1:0] pick_weight();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return WEIGHT_W'(1000 * $urandom_range(1, 3));
      3:       return WEIGHT_W'($urandom_range(60000, 65535));
      default: return WEIGHT_W'($urandom);
    endcase
  endfunction

  task automatic send_vertex(int unsigned n_adds, int unsigned span);
    int unsigned k;
    for (k = 0; k < n_adds; k++) send_item(ACT_ADD, pick_bone(span), pick_weight());
    send_item(ACT_FINALIZE, BONE_W'($urandom), WEIGHT_W'($urandom));
  endtask

  // Empty vertex, zero total, full table with ties, saturation, replacement,
  // dropped add and threshold pruning.
  task automatic test_directed();
    logic [WEIGHT_W-1:0] fill_weight [14];
    int unsigned         k;
    fill_weight = '{3000, 3000, 3000, 1500, 1200, 900, 800,
                    5000, 20000, 700, 650, 600, 12000, 1000};
    send_item(ACT_FINALIZE, '0, '0);
    send_item(ACT_ADD, 10'd3, '0);
    send_item(ACT_ADD, 10'd4, '0);
    send_item(ACT_ADD, 10'd1023, '0);
    send_item(ACT_FINALIZE, '1, '1);
    wait_drain();
    set_config(32'd16, 32'd1000);
    send_item(ACT_ADD, 10'd1023, 16'hFFFF);
    send_item(ACT_ADD, 10'd0, 16'd500);
    for (k = 0; k < 14; k++) send_item(ACT_ADD, BONE_W'(k + 1), fill_weight[k]);
    send_item(ACT_ADD, 10'd1023, 16'd1);
    send_item(ACT_ADD, 10'd2, 16'd200);
    send_item(ACT_ADD, 10'd100, 16'd500);
    send_item(ACT_ADD, 10'd101, 16'd700);
    send_item(ACT_FINALIZE, '0, '0);
    wait_drain();
  endtask

  // Random vertices over several register settings, extremes included.
  task automatic test_random();
    int unsigned phase_mbc [8];
    int unsigned phase_thr [8];
    int unsigned p;
    int unsigned stop_at;
    phase_mbc = '{1, 16, 0, 31, 4, 2, 16, 8};
    phase_thr = '{0, 0, 0, 16384, 8000, 65535, 2500, 0};
    for (p = 0; p < 8; p++) begin
      if (p == 7) begin
        phase_mbc[p] = $urandom_range(1, 16);
        phase_thr[p] = $urandom_range(0, 20000);
      end
      set_config(phase_mbc[p], phase_thr[p]);
      stop_at = items_sent + 32;
      while (items_sent < stop_at) begin
        if ($urandom_range(0, 3) == 0) send_vertex($urandom_range(14, 26), 23);
        else send_vertex($urandom_range(0, 8), 23);
      end
      wait_drain();
    end
  endtask

  // The receiver holds off while full vertices keep coming.
  task automatic test_backpressure();
    set_config(32'd16, 32'd0);
    hold_request = HOLD_CYCLES;
    repeat (3) send_vertex(18, 23);
    wait_drain();
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_streaming();
    set_config(32'd8, 32'd2000);
    no_idle = 1'b1;
    repeat (5) send_vertex($urandom_range(2, 12), 23);
    wait_drain();
  endtask

  // Receiver: random stall bursts, or a long hold-off on request.
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk_i);
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
        out_ready_i <= 1'b0;
        repeat (n) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // Compare every accepted influence with the oldest expectation.
  always @(posedge clk_i) begin
    influence_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_influences.size() == 0) begin
        report_error("influence emitted with none expected");
      end else begin
        want = pending_influences.pop_front();
        check_field("bone_id_res", 32'(bone_id_res_o), 32'(want.bone));
        check_field("norm_weight", 32'(norm_weight_o), 32'(want.weight));
        check_field("valid_res", 32'(valid_res_o), 32'(want.valid));
        check_field("last", 32'(last_o), 32'(want.last));
        check_field("kept_count", 32'(kept_count_o), 32'(want.kept));
        check_field("overflowed", 32'(overflowed_o), 32'(want.ovf));
      end
    end
  end

  // Watchdog on cycles with no item moving on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("bone_influence_table_tb: errors");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    tbl_bone      = '{default: '0};
    tbl_weight    = '{default: '0};
    tbl_count     = 0;
    tbl_ovf       = 1'b0;
    cfg_max_bones = MAX_BONE_RESET;
    cfg_threshold = THRESHOLD_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    test_backpressure();
    test_streaming();
    if (error_count == 0) begin
      $display("bone_influence_table_tb: clean");
    end else begin
      $display("bone_influence_table_tb: errors");
    end
    $finish;
  end

endmodule

// File: bone_influence_table.f
design/bif_pkg.sv
design/bif_cell.sv
design/bif_div.sv
design/bone_influence_table.sv
sim/bone_influence_table_tb.sv
